/* rtl/xorshift32_ranged_random_defines.svh */
// Assertion macros shared by the xorshift32 ranged random block.
// Used only by the top level; depends on nothing else.
`ifndef XORSHIFT32_RANGED_RANDOM_DEFINES_SVH
`define XORSHIFT32_RANGED_RANDOM_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define XRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define XRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/xrr_pkg.sv */
// Shared types, constants and the generator step function for the
// xorshift32 ranged random block. No dependencies.
package xrr_pkg;

    localparam int WordW      = 32;
    localparam int CntW       = $clog2(WordW);
    localparam int QueueDepth = 2;

    localparam logic [WordW-1:0] SeedReset = 32'd123456789;
    localparam int ShiftA = 13;
    localparam int ShiftB = 17;
    localparam int ShiftC = 5;

    // One request after the front end: lower bound, span and the new word.
    typedef struct packed {
        logic [WordW-1:0] lo;
        logic [WordW-1:0] span;
        logic [WordW-1:0] word;
    } t_job;

    // Status of the reduction engine, watched by the top level.
    typedef struct packed {
        logic busy;
        logic pop;
    } t_back_status;

    function automatic logic [WordW-1:0] xorshift_step(input logic [WordW-1:0] s);
        logic [WordW-1:0] t;
        t = s ^ (s << ShiftA);
        t = t ^ (t >> ShiftB);
        t = t ^ (t << ShiftC);
        return t;
    endfunction

endpackage

/* rtl/xrr_front.sv */
// Front end: holds the generator state, takes requests, advances the
// generator and forms the span. Depends on xrr_pkg.
module xrr_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_seed_we,
    input  logic [xrr_pkg::WordW-1:0] i_seed_wdata,
    input  logic                      i_valid,
    input  logic [xrr_pkg::WordW-1:0] i_range_min,
    input  logic [xrr_pkg::WordW-1:0] i_range_max,
    input  logic                      i_q_full,
    output logic                      o_ready,
    output logic                      o_push,
    output xrr_pkg::t_job             o_job
);
    import xrr_pkg::*;

    logic [WordW-1:0] r_gen;
    logic [WordW-1:0] n_gen;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign n_gen   = xorshift_step(r_gen);

    assign o_job.lo   = i_range_min;
    assign o_job.span = i_range_max - i_range_min + WordW'(1);
    assign o_job.word = n_gen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= SeedReset;
        end else if (i_seed_we) begin
            r_gen <= i_seed_wdata;
        end else if (o_push) begin
            r_gen <= n_gen;
        end
    end

endmodule

/* rtl/xrr_queue.sv */
// Small first-in first-out queue of jobs between front end and engine.
// Depends on xrr_pkg.
module xrr_queue #(
    parameter int Depth = xrr_pkg::QueueDepth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  xrr_pkg::t_job                i_job,
    input  logic                         i_pop,
    output xrr_pkg::t_job                o_job,
    output logic                         o_full,
    output logic                         o_empty,
    output logic [$clog2(Depth+1)-1:0]   o_count
);
    import xrr_pkg::*;

    localparam int PtrW = $clog2(Depth);
    localparam int CntQ = $clog2(Depth + 1);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntQ-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntQ'(Depth));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CntQ'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CntQ'(1);
            end
        end
    end

endmodule

/* rtl/xrr_back.sv */
// Reduction engine: bit-serial restoring remainder of the word by the span,
// then adds the lower bound into the output register. Depends on xrr_pkg.
module xrr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  xrr_pkg::t_job               i_job,
    output xrr_pkg::t_back_status       o_status,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [2*xrr_pkg::WordW-1:0] o_tdata
);
    import xrr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [CntW-1:0]  r_cnt;
    logic [WordW-1:0] r_rem;
    logic [WordW-1:0] r_dvd;
    logic [WordW-1:0] r_lo;
    logic [WordW-1:0] r_span;
    logic [WordW-1:0] r_word;
    logic             r_out_valid;
    logic [WordW-1:0] r_out_value;
    logic [WordW-1:0] r_out_word;

    logic [WordW:0]   rem_sh;
    logic [WordW:0]   rem_sub;
    logic             take;
    logic             pop;
    logic             load_out;

    // One quotient bit per cycle: shift in the next dividend bit, subtract
    // the span when it fits.
    assign rem_sh  = {r_rem, r_dvd[WordW-1]};
    assign rem_sub = rem_sh - {1'b0, r_span};
    assign take    = !rem_sub[WordW];

    assign pop             = (r_state == S_IDLE) && !i_empty;
    assign load_out        = (r_state == S_OUT) && (!r_out_valid || i_tready);
    assign o_status.busy   = (r_state != S_IDLE);
    assign o_status.pop    = pop;
    assign o_tvalid        = r_out_valid;
    assign o_tdata         = {r_out_word, r_out_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_tready && !load_out) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_lo   <= i_job.lo;
                        r_span <= i_job.span;
                        r_word <= i_job.word;
                        r_dvd  <= i_job.word;
                        r_cnt  <= '0;
                        if (i_job.span == '0) begin
                            // A span that wraps to zero means the whole word range.
                            r_rem   <= i_job.word;
                            r_state <= S_OUT;
                        end else begin
                            r_rem   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= take ? rem_sub[WordW-1:0] : rem_sh[WordW-1:0];
                    r_dvd <= r_dvd << 1;
                    r_cnt <= r_cnt + CntW'(1);
                    if (r_cnt == CntW'(WordW - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_lo + r_rem;
                        r_out_word  <= r_word;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/xorshift32_ranged_random.sv */
// Top level of the xorshift32 ranged random block: front end, job queue and
// reduction engine. Depends on xrr_pkg, xrr_front, xrr_queue, xrr_back and
// the assertion macros in xorshift32_ranged_random_defines.svh.
//
// Usage. Each request item on the slave stream carries range_min in tdata
// bits 31:0 and range_max in bits 63:32, both two's complement. For each
// accepted item the block advances a 32-bit xorshift generator and returns
// one result item on the master stream: value (min plus the new word modulo
// max - min + 1, wrapped to 32 bits) in bits 31:0 and the raw word in 63:32.
// When the span wraps to zero the full word is added to min instead.
// Writing the seed port loads the generator; a zero seed keeps it at zero.
// An accepted request enters the job queue; the idle engine pops it, the
// bit-serial remainder unit works through the word one bit at a time, and
// the engine loads the output register. When the span wraps to zero the
// remainder steps are skipped. The engine holds one item at a time, so the
// remainder unit sets the rate. The front end takes requests while the
// two-entry queue has room, so up to two requests wait behind the engine.
// A stalled receiver holds the result in the output register; the engine
// then waits in its output step and the queue fills before tready drops.
// Reset loads the seed 123456789 and empties the queue and output.
module xorshift32_ranged_random #(
    parameter int QueueDepth = xrr_pkg::QueueDepth
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_seed_we,
    input  logic [xrr_pkg::WordW-1:0]   i_seed_wdata,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // Fields from bit 0: range_min[31:0], range_max[31:0].
    input  logic [2*xrr_pkg::WordW-1:0] i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // Fields from bit 0: value[31:0], raw_word[31:0].
    output logic [2*xrr_pkg::WordW-1:0] o_m_axis_tdata
);
    import xrr_pkg::*;

    localparam int CntQ = $clog2(QueueDepth + 1);

    t_job            push_job;
    t_job            head_job;
    logic            push;
    logic            q_full;
    logic            q_empty;
    logic [CntQ-1:0] q_count;
    t_back_status    back_status;

    // The front end generates the word at acceptance, so the generator order
    // always matches the request order.
    xrr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_wdata (i_seed_wdata),
        .i_valid      (i_s_axis_tvalid),
        .i_range_min  (i_s_axis_tdata[WordW-1:0]),
        .i_range_max  (i_s_axis_tdata[2*WordW-1:WordW]),
        .i_q_full     (q_full),
        .o_ready      (o_s_axis_tready),
        .o_push       (push),
        .o_job        (push_job)
    );

    xrr_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (back_status.pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    xrr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_job    (head_job),
        .o_status (back_status),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );

`include "xorshift32_ranged_random_defines.svh"

    // An accepted request must be waiting in the queue or already taken.
    `XRR_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, (q_count != '0) || back_status.busy,
        "accepted item lost before the engine")

    // The queue never holds more than its depth.
    `XRR_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n,
        1'b1, q_count <= CntQ'(QueueDepth), "queue count beyond depth")

    // An idle engine with a waiting job starts on it in the next cycle.
    `XRR_ASSERT_NEXT(a_engine_starts, i_clk, i_rst_n,
        !q_empty && !back_status.busy, back_status.busy,
        "engine idle while a job waits")

endmodule
